// ===== sv/rcwm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcwm_pkg
// Shared widths, register indexes and the history entry type of the
// recent contact window matcher.
// ----------------------------------------------------------------------------
package rcwm_pkg;

	localparam int ADDR_W    = 48;
	localparam int TIME_W    = 64;
	localparam int REG_W     = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_AGE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE = 1'd1;

	localparam logic [REG_W-1:0] MIN_AGE_RST = 16'd240;   // 4 minutes
	localparam logic [REG_W-1:0] MAX_AGE_RST = 16'd1200;  // 20 minutes

	localparam logic ACT_RECORD = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [TIME_W-1:0] stamp;
	} entry_t;

endpackage
`default_nettype wire

// ===== sv/rcwm_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcwm channel interfaces
// Valid/ready channels for sighting/query items and for match results.
// ----------------------------------------------------------------------------
interface rcwm_req_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [rcwm_pkg::ADDR_W-1:0] contact_addr;
	logic [rcwm_pkg::TIME_W-1:0] event_sec;

	modport source (output valid, action, contact_addr, event_sec, input ready);
	modport sink   (input valid, action, contact_addr, event_sec, output ready);
endinterface

interface rcwm_rsp_if;
	logic valid;
	logic ready;
	logic close_match;

	modport source (output valid, close_match, input ready);
	modport sink   (input valid, close_match, output ready);
endinterface
`default_nettype wire

// ===== sv/recent_contact_window_match.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// recent_contact_window_match
// Record: the entry is written into the history RAM; the next item follows in the next cycle.
// Query: the result is valid after the one-entry-per-cycle scan of the RAM read
//   port and two compare stages; the next item is taken once the result is
//   loaded, later while the previous result still waits on rsp.ready.
// Reset: registers take their defaults, pointer and fill count clear; entries
//   past the fill count read as zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module recent_contact_window_match #(
	parameter int HISTORY_DEPTH = 120
) (
	input  wire                            clk,
	input  wire                            arst_n,
	rcwm_req_if.sink                       req,
	rcwm_rsp_if.source                     rsp,
	input  wire                            cfg_wr_en,
	input  wire [rcwm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [rcwm_pkg::REG_W-1:0]      cfg_data
);

	localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(HISTORY_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(HISTORY_DEPTH);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	rcwm_pkg::entry_t mem [HISTORY_DEPTH];

	logic [1:0]                  state_q;
	logic [rcwm_pkg::REG_W-1:0]  min_age_q, max_age_q;
	logic [PTR_W-1:0]            wr_ptr_q, rd_idx_q;
	logic [CNT_W-1:0]            fill_q;
	logic [rcwm_pkg::ADDR_W-1:0] query_addr_q;
	logic [rcwm_pkg::TIME_W-1:0] query_time_q;
	logic                        hit_q;
	logic                        out_valid_q, close_match_q;

	logic                        vld_s1, idx_ok_s1;
	rcwm_pkg::entry_t            rdata_s1;
	logic                        vld_s2, addr_eq_s2;
	logic [rcwm_pkg::TIME_W-1:0] age_s2;

	logic                        req_xfer, rec_xfer, qry_xfer;
	logic                        rsp_xfer, rsp_load, pipe_empty;
	rcwm_pkg::entry_t            entry_s1;

	assign req.ready   = (state_q == ST_IDLE);
	assign req_xfer    = req.valid && req.ready;
	assign rec_xfer    = req_xfer && (req.action == rcwm_pkg::ACT_RECORD);
	assign qry_xfer    = req_xfer && (req.action == rcwm_pkg::ACT_QUERY);
	assign rsp_xfer    = out_valid_q && rsp.ready;
	assign pipe_empty  = !vld_s1 && !vld_s2;
	assign rsp_load    = (state_q == ST_DRAIN) && pipe_empty && (!out_valid_q || rsp.ready);
	assign rsp.valid       = out_valid_q;
	assign rsp.close_match = close_match_q;

	// unwritten entries behave as address 0, time 0
	assign entry_s1 = idx_ok_s1 ? rdata_s1 : '0;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_age_q <= rcwm_pkg::MIN_AGE_RST;
			max_age_q <= rcwm_pkg::MAX_AGE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				rcwm_pkg::REG_MIN_AGE: min_age_q <= cfg_data;
				rcwm_pkg::REG_MAX_AGE: max_age_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// history RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (rec_xfer) begin
			mem[wr_ptr_q] <= '{addr: req.contact_addr, stamp: req.event_sec};
		end
		if (state_q == ST_SCAN) begin
			rdata_s1 <= mem[rd_idx_q];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wr_ptr_q <= '0;
			fill_q   <= '0;
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			hit_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN);
			vld_s2 <= vld_s1;
			case (state_q)
				ST_IDLE: begin
					if (rec_xfer) begin
						wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
						if (fill_q != FULL_CNT) begin
							fill_q <= fill_q + 1'b1;
						end
					end
					if (qry_xfer) begin
						rd_idx_q <= '0;
						hit_q    <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_idx_q <= rd_idx_q + 1'b1;
					if (rd_idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (vld_s2 && addr_eq_s2
					&& age_s2 > {{(rcwm_pkg::TIME_W - rcwm_pkg::REG_W){1'b0}}, min_age_q}
					&& age_s2 < {{(rcwm_pkg::TIME_W - rcwm_pkg::REG_W){1'b0}}, max_age_q}) begin
				hit_q <= 1'b1;
			end
			if (rsp_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_xfer) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (qry_xfer) begin
			query_addr_q <= req.contact_addr;
			query_time_q <= req.event_sec;
		end
		if (state_q == ST_SCAN) begin
			idx_ok_s1 <= CNT_W'(rd_idx_q) < fill_q;
		end
		if (vld_s1) begin
			addr_eq_s2 <= (entry_s1.addr == query_addr_q);
			age_s2     <= query_time_q - entry_s1.stamp;  // modulo 2^64
		end
		if (rsp_load) begin
			close_match_q <= hit_q;
		end
	end

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count past depth");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_ptr_q <= LAST_IDX)
		else $error("write pointer past last entry");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_xfer && fill_q != FULL_CNT) |=> (fill_q == $past(fill_q) + 1'b1))
		else $error("fill count did not follow record");

	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> $past(vld_s1))
		else $error("stage 2 valid without stage 1");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished query did not present a result");

endmodule
`default_nettype wire
